// ===== hdl/smrt_pkg.sv =====
// ----------------------------------------------------------------------------
// smrt_pkg: shared types and constants of the source match route table
// Widths, status and function codes, and the request and result structs.
// ----------------------------------------------------------------------------
package smrt_pkg;

  localparam int unsigned MAX_ROUTES = 16;
  localparam int unsigned NUM_PORTS  = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_ROUTES);
  localparam int unsigned CNT_W      = $clog2(MAX_ROUTES + 1);
  localparam logic [15:0] MTU_EMPTY  = 16'hFFFF;

  localparam logic [2:0] FN_FWD  = 3'd0;
  localparam logic [2:0] FN_SET  = 3'd1;
  localparam logic [2:0] FN_DEL  = 3'd2;
  localparam logic [2:0] FN_READ = 3'd3;
  localparam logic [2:0] FN_UP   = 3'd4;

  typedef enum logic [2:0] {
    ST_FWD      = 3'd0,
    ST_FAMILY   = 3'd1,
    ST_DOWN     = 3'd2,
    ST_NOROUTE  = 3'd3,
    ST_PORTDOWN = 3'd4,
    ST_DONE     = 3'd5,
    ST_BADIDX   = 3'd6,
    ST_FULL     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    K_FWD  = 3'd0,
    K_SET  = 3'd1,
    K_DEL  = 3'd2,
    K_READ = 3'd3,
    K_UP   = 3'd4,
    K_BAD  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]           func;
    logic                 is_inet;
    logic [31:0]          src_addr;
    logic [15:0]          packet_length;
    logic [NUM_PORTS-1:0] ports_up;
    logic [4:0]           index;
    logic [31:0]          match_value;
    logic [31:0]          mask_value;
    logic [3:0]           port;
    logic [31:0]          next_hop_addr;
    logic [15:0]          port_mtu;
    logic                 up_request;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  out_port;
    logic [31:0] next_hop;
    logic [31:0] entry_match;
    logic [31:0] entry_mask;
    logic [4:0]  route_total;
    logic [15:0] current_mtu;
    logic [31:0] packet_total;
    logic [31:0] error_total;
    logic [31:0] byte_total;
    logic        iface_is_up;
  } out_item_t;

  typedef struct packed {
    kind_e    kind;
    in_item_t item;
  } req_t;

endpackage

// ===== hdl/smrt_front.sv =====
// ----------------------------------------------------------------------------
// smrt_front: request intake and classification
// Decodes each request and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module smrt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  smrt_pkg::in_item_t in_item_i,
  output logic              head_valid_o,
  output smrt_pkg::req_t    head_o,
  input  logic              pop_i
);

  smrt_pkg::req_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push;
  logic           pop;
  smrt_pkg::req_t req;

  always_comb begin
    req.item = in_item_i;
    case (in_item_i.func)
      smrt_pkg::FN_FWD:  req.kind = smrt_pkg::K_FWD;
      smrt_pkg::FN_SET:  req.kind = smrt_pkg::K_SET;
      smrt_pkg::FN_DEL:  req.kind = smrt_pkg::K_DEL;
      smrt_pkg::FN_READ: req.kind = smrt_pkg::K_READ;
      smrt_pkg::FN_UP:   req.kind = smrt_pkg::K_UP;
      default:           req.kind = smrt_pkg::K_BAD;
    endcase
  end

  assign in_stall_o   = (fill_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (fill_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= req;
    end
  end

endmodule

// ===== hdl/smrt_back.sv =====
// ----------------------------------------------------------------------------
// smrt_back: route table execution
// Holds the table and counters, runs each request and drives the result.
// ----------------------------------------------------------------------------
module smrt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mtu_lock_i,
  input  logic               head_valid_i,
  input  smrt_pkg::req_t     head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output smrt_pkg::out_item_t out_item_o
);

  localparam int unsigned N = smrt_pkg::MAX_ROUTES;
  localparam int unsigned IW = smrt_pkg::IDX_W;
  localparam int unsigned CW = smrt_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_EXEC = 5'b00100,
    S_MTU  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  typedef struct packed {
    smrt_pkg::status_e status;
    logic [3:0]        out_port;
    logic [31:0]       next_hop;
    logic [31:0]       entry_match;
    logic [31:0]       entry_mask;
  } part_t;

  logic [31:0] match_q [N];
  logic [31:0] mask_q  [N];
  logic [3:0]  port_q  [N];
  logic [31:0] hop_q   [N];
  logic [15:0] mtu_e_q [N];

  state_e              state_q, state_d;
  smrt_pkg::req_t      req_q;
  logic [N-1:0]        hit_q;
  part_t               part_q, part_d;
  logic [CW-1:0]       count_q, count_d;
  logic                up_q, up_d;
  logic [15:0]         mtu_q, mtu_d;
  logic [31:0]         pkt_q, pkt_d, err_q, err_d, byte_q, byte_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [15:0]         min_q, min_d;
  logic                out_valid_q, out_valid_d;
  smrt_pkg::out_item_t out_q;
  logic                wr_en, del_en, free;
  logic                any_hit;
  logic [IW-1:0]       hit_idx;
  logic [IW-1:0]       idx;
  logic [CW-1:0]       idx_full;

  assign free        = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && head_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign idx_full    = req_q.item.index[CW-1:0];
  assign idx         = req_q.item.index[IW-1:0];

  // First matching entry wins: scan from the top so the lowest index is left.
  always_comb begin
    any_hit = |hit_q;
    hit_idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (hit_q[k]) begin
        hit_idx = IW'(k);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    part_d      = part_q;
    count_d     = count_q;
    up_d        = up_q;
    mtu_d       = mtu_q;
    pkt_d       = pkt_q;
    err_d       = err_q;
    byte_d      = byte_q;
    scan_d      = scan_q;
    min_d       = min_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    del_en      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        part_d  = '{status: smrt_pkg::ST_BADIDX, default: '0};
        state_d = S_DONE;
        case (req_q.kind)
          smrt_pkg::K_FWD: begin
            if (!req_q.item.is_inet) begin
              part_d.status = smrt_pkg::ST_FAMILY;
            end else if (!up_q) begin
              part_d.status = smrt_pkg::ST_DOWN;
            end else begin
              pkt_d = pkt_q + 32'd1;
              if (!any_hit) begin
                err_d         = err_q + 32'd1;
                part_d.status = smrt_pkg::ST_NOROUTE;
              end else begin
                byte_d          = byte_q + {16'd0, req_q.item.packet_length};
                part_d.out_port = port_q[hit_idx];
                part_d.next_hop = hop_q[hit_idx];
                if ({1'b0, port_q[hit_idx]} < 5'(smrt_pkg::NUM_PORTS) &&
                    req_q.item.ports_up[port_q[hit_idx]]) begin
                  part_d.status = smrt_pkg::ST_FWD;
                end else begin
                  part_d.status = smrt_pkg::ST_PORTDOWN;
                end
              end
            end
          end
          smrt_pkg::K_SET: begin
            if (req_q.item.index > 5'(count_q)) begin
              part_d.status = smrt_pkg::ST_BADIDX;
            end else if (req_q.item.index >= 5'(N)) begin
              part_d.status = smrt_pkg::ST_FULL;
            end else begin
              wr_en         = 1'b1;
              part_d.status = smrt_pkg::ST_DONE;
              if (idx_full == count_q) begin
                count_d = count_q + CW'(1);
              end
            end
          end
          smrt_pkg::K_DEL: begin
            if (req_q.item.index >= 5'(count_q)) begin
              part_d.status = smrt_pkg::ST_BADIDX;
            end else begin
              del_en        = 1'b1;
              count_d       = count_q - CW'(1);
              part_d.status = smrt_pkg::ST_DONE;
              if (count_q == CW'(1)) begin
                up_d = 1'b0;
              end
            end
          end
          smrt_pkg::K_READ: begin
            if (req_q.item.index >= 5'(count_q)) begin
              part_d.status = smrt_pkg::ST_BADIDX;
            end else begin
              part_d.status      = smrt_pkg::ST_DONE;
              part_d.out_port    = port_q[idx];
              part_d.next_hop    = hop_q[idx];
              part_d.entry_match = match_q[idx];
              part_d.entry_mask  = mask_q[idx];
            end
          end
          smrt_pkg::K_UP: begin
            up_d          = req_q.item.up_request && (count_q != '0);
            part_d.status = smrt_pkg::ST_DONE;
          end
          default: begin
            part_d.status = smrt_pkg::ST_BADIDX;
          end
        endcase
        if ((wr_en || del_en) && !mtu_lock_i) begin
          state_d = S_MTU;
          scan_d  = '0;
          min_d   = smrt_pkg::MTU_EMPTY;
        end
      end
      S_MTU: begin
        if (scan_q < count_q) begin
          if (mtu_e_q[scan_q[IW-1:0]] < min_q) begin
            min_d = mtu_e_q[scan_q[IW-1:0]];
          end
          scan_d = scan_q + CW'(1);
        end else begin
          mtu_d   = min_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      up_q        <= 1'b0;
      mtu_q       <= smrt_pkg::MTU_EMPTY;
      pkt_q       <= '0;
      err_q       <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      up_q        <= up_d;
      mtu_q       <= mtu_d;
      pkt_q       <= pkt_d;
      err_q       <= err_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    scan_q <= scan_d;
    min_q  <= min_d;
    if (pop_o) begin
      req_q <= head_i;
    end
    if (state_q == S_LOOK) begin
      for (int k = 0; k < N; k++) begin
        hit_q[k] <= (CW'(k) < count_q) &&
                    ((req_q.item.src_addr & mask_q[k]) == match_q[k]);
      end
    end
    if (state_q == S_DONE && free) begin
      out_q <= '{status:       part_q.status,
                 out_port:     part_q.out_port,
                 next_hop:     part_q.next_hop,
                 entry_match:  part_q.entry_match,
                 entry_mask:   part_q.entry_mask,
                 route_total:  5'(count_q),
                 current_mtu:  mtu_q,
                 packet_total: pkt_q,
                 error_total:  err_q,
                 byte_total:   byte_q,
                 iface_is_up:  up_q};
    end
  end

  // Table storage: a set writes one row, a delete moves every row above the
  // deleted one down by one place.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (wr_en && idx == IW'(k)) begin
        match_q[k] <= req_q.item.match_value;
        mask_q[k]  <= req_q.item.mask_value;
        port_q[k]  <= req_q.item.port;
        hop_q[k]   <= req_q.item.next_hop_addr;
        mtu_e_q[k] <= req_q.item.port_mtu;
      end else if (del_en && IW'(k) >= idx && k < N - 1) begin
        match_q[k] <= match_q[(k + 1) % N];
        mask_q[k]  <= mask_q[(k + 1) % N];
        port_q[k]  <= port_q[(k + 1) % N];
        hop_q[k]   <= hop_q[(k + 1) % N];
        mtu_e_q[k] <= mtu_e_q[(k + 1) % N];
      end
    end
  end

endmodule

// ===== hdl/source_match_route_table_top.sv =====
// ----------------------------------------------------------------------------
// source_match_route_table_top: first-match masked source route table
// Ordered table of up to sixteen masked source routes with lookup, table
// maintenance, interface MTU tracking and traffic counters.
// ----------------------------------------------------------------------------
// Each request passes through the lookup, execute and done states of the back
// end; a set or delete with the MTU unlocked adds a scan of every route's MTU.
// The back end sequencer handles one request at a time and takes the next only
// once the result is registered; the front end queue can still take requests.
// Reset clears the table count, counters, up flag and MTU (to 65535) at once.
module source_match_route_table_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mtu_lock_we_i,
  input  logic                mtu_lock_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  smrt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output smrt_pkg::out_item_t out_item_o
);

  // MTU lock register; user writes it only while the block is idle, not enforced.
  logic mtu_lock_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_lock_q <= 1'b0;
    end else if (mtu_lock_we_i) begin
      mtu_lock_q <= mtu_lock_wdata_i;
    end
  end

  // The front end decodes each request and queues it, so that a new request
  // can be taken while the back end is busy or its result waits.
  logic           head_valid;
  smrt_pkg::req_t head;
  logic           pop;

  smrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // The back end looks up, updates the table and counters, rescans the MTU
  // when needed and holds the result in its output register.
  smrt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mtu_lock_i   (mtu_lock_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

// ===== hdl/smrt_checker.sv =====
// ----------------------------------------------------------------------------
// smrt_checker: port level checks of the route table
// Watches the top level ports and reports broken rules with $error.
// ----------------------------------------------------------------------------
module smrt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input smrt_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_fwd_needs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == smrt_pkg::ST_FWD |->
      out_item_o.iface_is_up && out_item_o.route_total != 5'd0)
    else $error("forwarded with interface down or empty table");

  a_up_needs_routes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.iface_is_up |-> out_item_o.route_total != 5'd0)
    else $error("interface up with an empty table");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.route_total <= 5'(smrt_pkg::MAX_ROUTES))
    else $error("route total beyond table size");

endmodule

bind source_match_route_table_top smrt_checker u_smrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
